// ----- sv/banded_pair_midpoint_histogram_core_defines.svh -----
// Assertion macros for the banded pair midpoint histogram core.
// Define NO_ASSERTIONS to compile them away.
`ifndef BANDED_PAIR_MIDPOINT_HISTOGRAM_CORE_DEFINES_SVH
`define BANDED_PAIR_MIDPOINT_HISTOGRAM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define BMH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BMH_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/bmh_pkg.sv -----
`default_nettype none

package bmh_pkg;

  // store geometry
  localparam int NUM_BINS = 8192;
  localparam int BIN_AW   = $clog2(NUM_BINS);

  // field widths
  localparam int POS_W     = 28;
  localparam int BIN_W     = 13;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = POS_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);

  localparam logic [BIN_AW-1:0] CLR_LAST = BIN_AW'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // register reset values
  localparam logic [POS_W-1:0] BIN_WIDTH_RST = POS_W'(40000);
  localparam logic [POS_W-1:0] SHIFT_RST     = POS_W'(0);
  localparam logic [POS_W-1:0] WINDOW_RST    = POS_W'(1000000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    RES_NONE,
    RES_BAND_MISS,
    RES_IDX_OOR,
    RES_READ,
    RES_UPDATE
  } res_sel_e;

  typedef struct packed {
    logic     clr_we;
    logic     capture;
    logic     calc;
    logic     div_start;
    logic     rd_en;
    logic     rd_from_quot;
    logic     upd_we;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_func;
    logic in_band;
    logic div_done;
    logic idx_oor;
    logic rb_oor;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/bmh_channels.sv -----
`default_nettype none

interface bmh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [bmh_pkg::POS_W-1:0]  pos_a;
  logic [bmh_pkg::POS_W-1:0]  pos_b;
  logic [bmh_pkg::BIN_W-1:0]  read_bin;

  modport source (output valid, func, pos_a, pos_b, read_bin, input ready);
  modport sink   (input valid, func, pos_a, pos_b, read_bin, output ready);
endinterface

interface bmh_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic                       out_of_range;
  logic [bmh_pkg::BIN_W-1:0]  bin;
  logic [bmh_pkg::CNT_W-1:0]  count;

  modport source (output valid, accepted, out_of_range, bin, count, input ready);
  modport sink   (input valid, accepted, out_of_range, bin, count, output ready);
endinterface

interface bmh_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmh_pkg::CFG_IDX_W-1:0] index;
  logic [bmh_pkg::POS_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/banded_pair_midpoint_histogram_core.sv -----
`default_nettype none
// Banded pair midpoint histogram core.
//
// Channels: in_i takes items (func 0 records the pair pos_a/pos_b, func 1
// reads the count of read_bin); out_o returns exactly one result per item;
// cfg_i writes bin_width (0), shift_distance (1) and window_half (2). The
// config channel is always ready; write it only while the core is idle.
// A transaction on any channel completes on a clock edge with valid and
// ready both high.
// Flow, input transaction to result valid: a record is captured, goes through
// calc and the band check and, in band, runs the 28-step restoring divider
// (one quotient bit per cycle), then the index check and, inside the store,
// the count update. A read looks up read_bin in the count RAM when it lies
// inside the store. The next input is taken in the cycle after the result is
// loaded, so the divider sets how long an in-band record occupies the core.
// Reset: after rst_ni releases, the core sweeps the count RAM to zero, one
// bin per cycle, across all NUM_BINS (8192) bins; in_i.ready stays low meanwhile.
// Stall: a result waits in the output register while out_o.ready is low;
// the core still takes and works the next item, then holds until the
// output register frees.

`include "banded_pair_midpoint_histogram_core_defines.svh"

module banded_pair_midpoint_histogram_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmh_cfg_if.sink   cfg_i,
  bmh_in_if.sink    in_i,
  bmh_out_if.source out_o
);

  bmh_pkg::cmd_t    cmd;
  bmh_pkg::status_t status;

  // Register writes land directly; no back-pressure on config.
  assign cfg_i.ready = 1'b1;

  // Sequencer: clear sweep, record/read flow, output register valid.
  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Distance/band check, divider, count RAM and result registers.
  bmh_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .func_i         (in_i.func),
    .pos_a_i        (in_i.pos_a),
    .pos_b_i        (in_i.pos_b),
    .read_bin_i     (in_i.read_bin),
    .cmd_i          (cmd),
    .status_o       (status),
    .accepted_o     (out_o.accepted),
    .out_of_range_o (out_o.out_of_range),
    .bin_o          (out_o.bin),
    .count_o        (out_o.count)
  );

  // No input transaction while the store is being cleared.
  `BMH_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, cmd.clr_we |-> !in_i.ready, "input ready during clear")

  // One item at a time: after an input transaction the core is busy.
  `BMH_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "ready right after accept")

  // A waiting result is never overwritten.
  `BMH_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd.out_load |-> (!out_o.valid || out_o.ready), "output overwritten")

  // A counted record always reports a nonzero count and never out of range.
  `BMH_ASSERT(a_counted_result, clk_i, rst_ni, (out_o.valid && out_o.accepted) |-> (out_o.count != '0 && !out_o.out_of_range), "bad counted result")

endmodule

`default_nettype wire

// ----- sv/bmh_ram.sv -----
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/bmh_div.sv -----
`default_nettype none

module bmh_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bmh_pkg::POS_W-1:0] dividend_i,
  input  logic [bmh_pkg::POS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bmh_pkg::POS_W-1:0] quot_o
);

  logic                        busy_q, busy_d;
  logic [bmh_pkg::DIV_CW-1:0]  cnt_q, cnt_d;
  logic [bmh_pkg::POS_W-1:0]   rem_q, rem_d;
  logic [bmh_pkg::POS_W-1:0]   quot_q, quot_d;
  logic [bmh_pkg::POS_W:0]     shifted;
  logic [bmh_pkg::POS_W:0]     diff;
  logic                        last;

  assign shifted = {rem_q, quot_q[bmh_pkg::POS_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign last    = (cnt_q == bmh_pkg::DIV_LAST);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = dividend_i;
    end else if (busy_q) begin
      // trial subtract; keep it when non-negative
      if (!diff[bmh_pkg::POS_W]) begin
        rem_d  = diff[bmh_pkg::POS_W-1:0];
        quot_d = {quot_q[bmh_pkg::POS_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[bmh_pkg::POS_W-1:0];
        quot_d = {quot_q[bmh_pkg::POS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + bmh_pkg::DIV_CW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = busy_q && last;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- sv/bmh_datapath.sv -----
`default_nettype none

module bmh_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register writes
  input  logic                          cfg_we_i,
  input  logic [bmh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bmh_pkg::POS_W-1:0]     cfg_data_i,
  // input payload
  input  logic                          func_i,
  input  logic [bmh_pkg::POS_W-1:0]     pos_a_i,
  input  logic [bmh_pkg::POS_W-1:0]     pos_b_i,
  input  logic [bmh_pkg::BIN_W-1:0]     read_bin_i,
  // control
  input  bmh_pkg::cmd_t                 cmd_i,
  output bmh_pkg::status_t              status_o,
  // output payload
  output logic                          accepted_o,
  output logic                          out_of_range_o,
  output logic [bmh_pkg::BIN_W-1:0]     bin_o,
  output logic [bmh_pkg::CNT_W-1:0]     count_o
);

  localparam int PW = bmh_pkg::POS_W;

  // configuration
  logic [PW-1:0] bin_width_q, shift_q, window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= bmh_pkg::BIN_WIDTH_RST;
      shift_q     <= bmh_pkg::SHIFT_RST;
      window_q    <= bmh_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmh_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_data_i;
        bmh_pkg::CFG_SHIFT:     shift_q     <= cfg_data_i;
        bmh_pkg::CFG_WINDOW:    window_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured item
  logic [PW-1:0]             a_q, b_q;
  logic [bmh_pkg::BIN_W-1:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q  <= pos_a_i;
      b_q  <= pos_b_i;
      rb_q <= read_bin_i;
    end
  end

  // distance, midpoint and band bounds
  logic [PW-1:0]        dist_d, dist_q, mid_q;
  logic [PW:0]          sum_d;
  logic signed [PW+1:0] lo_d, lo_q;
  logic [PW:0]          hi_d, hi_q;

  assign dist_d = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
  assign sum_d  = {1'b0, a_q} + {1'b0, b_q};
  assign lo_d   = $signed({2'b00, shift_q}) - $signed({2'b00, window_q});
  assign hi_d   = {1'b0, shift_q} + {1'b0, window_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      dist_q <= dist_d;
      mid_q  <= sum_d[PW:1];
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

  // midpoint / bin width
  logic [PW-1:0] divisor, quot;
  logic          div_done;

  assign divisor = (bin_width_q == '0) ? PW'(1) : bin_width_q;

  bmh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mid_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // bin addressing
  logic [31:0]                rb_ext, quot_ext;
  logic [bmh_pkg::BIN_AW-1:0] rb_addr, quot_addr;
  logic                       rb_oor, idx_oor;

  assign rb_ext    = 32'(rb_q);
  assign quot_ext  = 32'(quot);
  assign rb_addr   = rb_ext[bmh_pkg::BIN_AW-1:0];
  assign quot_addr = quot[bmh_pkg::BIN_AW-1:0];
  assign rb_oor    = (rb_ext >= 32'(bmh_pkg::NUM_BINS));
  assign idx_oor   = (quot_ext >= 32'(bmh_pkg::NUM_BINS));

  // clearing sweep address
  logic [bmh_pkg::BIN_AW-1:0] clr_q;
  logic                       clr_last;

  assign clr_last = (clr_q == bmh_pkg::CLR_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_last ? '0 : clr_q + bmh_pkg::BIN_AW'(1);
    end
  end

  // count store
  logic [bmh_pkg::CNT_W-1:0]  rdata, inc;
  logic                       ram_we;
  logic [bmh_pkg::BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [bmh_pkg::CNT_W-1:0]  ram_wdata;

  assign inc       = (rdata == bmh_pkg::CNT_MAX) ? rdata : rdata + bmh_pkg::CNT_W'(1);
  assign ram_we    = cmd_i.clr_we | cmd_i.upd_we;
  assign ram_waddr = cmd_i.clr_we ? clr_q : quot_addr;
  assign ram_wdata = cmd_i.clr_we ? '0 : inc;
  assign ram_raddr = cmd_i.rd_from_quot ? quot_addr : rb_addr;

  bmh_ram #(
    .WIDTH (bmh_pkg::CNT_W),
    .DEPTH (bmh_pkg::NUM_BINS)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // result staging and output register
  logic                      res_acc_q, res_oor_q;
  logic [bmh_pkg::BIN_W-1:0] res_bin_q;
  logic [bmh_pkg::CNT_W-1:0] res_cnt_q;
  logic                      out_acc_q, out_oor_q;
  logic [bmh_pkg::BIN_W-1:0] out_bin_q;
  logic [bmh_pkg::CNT_W-1:0] out_cnt_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      bmh_pkg::RES_BAND_MISS: begin
        res_acc_q <= 1'b0;
        res_oor_q <= 1'b0;
        res_bin_q <= '0;
        res_cnt_q <= '0;
      end
      bmh_pkg::RES_IDX_OOR: begin
        res_acc_q <= 1'b0;
        res_oor_q <= 1'b1;
        res_bin_q <= '0;
        res_cnt_q <= '0;
      end
      bmh_pkg::RES_READ: begin
        res_acc_q <= 1'b0;
        res_oor_q <= rb_oor;
        res_bin_q <= rb_q;
        res_cnt_q <= rb_oor ? '0 : rdata;
      end
      bmh_pkg::RES_UPDATE: begin
        res_acc_q <= 1'b1;
        res_oor_q <= 1'b0;
        res_bin_q <= quot[bmh_pkg::BIN_W-1:0];
        res_cnt_q <= inc;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_acc_q <= res_acc_q;
      out_oor_q <= res_oor_q;
      out_bin_q <= res_bin_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign accepted_o     = out_acc_q;
  assign out_of_range_o = out_oor_q;
  assign bin_o          = out_bin_q;
  assign count_o        = out_cnt_q;

  assign status_o.clr_last = clr_last;
  assign status_o.in_func  = func_i;
  assign status_o.in_band  = ($signed({2'b00, dist_q}) > lo_q) && ({1'b0, dist_q} < hi_q);
  assign status_o.div_done = div_done;
  assign status_o.idx_oor  = idx_oor;
  assign status_o.rb_oor   = rb_oor;

endmodule

`default_nettype wire

// ----- sv/bmh_ctrl.sv -----
`default_nettype none

module bmh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bmh_pkg::status_t status_i,
  output bmh_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_CALC  = 10'b00_0000_0100,
    S_BAND  = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_IDX   = 10'b00_0010_0000,
    S_UPD   = 10'b00_0100_0000,
    S_READ  = 10'b00_1000_0000,
    S_RDATA = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = status_i.in_func ? S_READ : S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_BAND;
      end
      S_BAND: begin
        if (status_i.in_band) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.res_sel = bmh_pkg::RES_BAND_MISS;
          state_d       = S_FIN;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_IDX;
      end
      S_IDX: begin
        if (status_i.idx_oor) begin
          cmd_o.res_sel = bmh_pkg::RES_IDX_OOR;
          state_d       = S_FIN;
        end else begin
          cmd_o.rd_en        = 1'b1;
          cmd_o.rd_from_quot = 1'b1;
          state_d            = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd_we  = 1'b1;
        cmd_o.res_sel = bmh_pkg::RES_UPDATE;
        state_d       = S_FIN;
      end
      S_READ: begin
        if (status_i.rb_oor) begin
          cmd_o.res_sel = bmh_pkg::RES_READ;
          state_d       = S_FIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_RDATA;
        end
      end
      S_RDATA: begin
        cmd_o.res_sel = bmh_pkg::RES_READ;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // load only once the output slot is free or draining
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- tb/bmh_tb_pkg.sv -----
`timescale 1ns / 100ps

package bmh_tb_pkg;

  // item operation codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // register index with no register behind it
  localparam logic [bmh_pkg::CFG_IDX_W-1:0] CFG_SPARE = bmh_pkg::CFG_IDX_W'(3);

endpackage

// ----- tb/bmh_checker.sv -----
`timescale 1ns / 100ps

module bmh_checker
  import bmh_pkg::*;
  import bmh_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bmh_cfg_if   cfg_mon,
  bmh_in_if    in_mon,
  bmh_out_if   out_mon,
  output int   mismatches_o,
  output int   pending_o
);

  typedef struct packed {
    logic             accepted;
    logic             out_of_range;
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic [CNT_W-1:0] shadow_counts [NUM_BINS];
  logic [POS_W-1:0] width_q;
  logic [POS_W-1:0] shift_q;
  logic [POS_W-1:0] window_q;
  outcome_t         outcome_fifo [$];
  outcome_t         got;
  outcome_t         want;
  int               bad;

  // Outcome of one item; a counted record also bumps the shadow store.
  function automatic outcome_t bin_outcome(input logic f, input logic [POS_W-1:0] a,
                                           input logic [POS_W-1:0] b,
                                           input logic [BIN_W-1:0] rb);
    outcome_t r;
    longint   gap;
    longint   lo;
    longint   hi;
    longint   w;
    longint   mid;
    longint   idx;
    r = '0;
    if (f == FUNC_READ) begin
      r.bin = rb;
      if (rb >= NUM_BINS) r.out_of_range = 1'b1;
      else r.count = shadow_counts[rb];
      return r;
    end
    gap = (a >= b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
    lo  = longint'(shift_q) - longint'(window_q);
    hi  = longint'(shift_q) + longint'(window_q);
    if (!(gap > lo && gap < hi)) return r;
    w   = (width_q == '0) ? 1 : longint'(width_q);
    mid = (longint'(a) + longint'(b)) >>> 1;
    idx = mid / w;
    if (idx >= NUM_BINS) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (shadow_counts[idx] != CNT_MAX) shadow_counts[idx] = shadow_counts[idx] + 1'b1;
    r.accepted = 1'b1;
    r.bin      = BIN_W'(idx);
    r.count    = shadow_counts[idx];
    return r;
  endfunction

  task automatic log_mismatch(input string why, input outcome_t w, input outcome_t g);
    bad++;
    if (bad <= 10)
      $display("%t %s: want acc=%0b oor=%0b bin=%0d cnt=%0d, got acc=%0b oor=%0b bin=%0d cnt=%0d",
               $realtime, why, w.accepted, w.out_of_range, w.bin, w.count,
               g.accepted, g.out_of_range, g.bin, g.count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) shadow_counts[i] = '0;
      width_q  = BIN_WIDTH_RST;
      shift_q  = SHIFT_RST;
      window_q = WINDOW_RST;
      outcome_fifo.delete();
      bad = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BIN_WIDTH: width_q  = cfg_mon.data;
          CFG_SHIFT:     shift_q  = cfg_mon.data;
          CFG_WINDOW:    window_q = cfg_mon.data;
          default: ;
        endcase
      end
      // results first: a result never belongs to an item taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.accepted     = out_mon.accepted;
        got.out_of_range = out_mon.out_of_range;
        got.bin          = out_mon.bin;
        got.count        = out_mon.count;
        if (outcome_fifo.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = outcome_fifo.pop_front();
          if (got.accepted !== want.accepted || got.out_of_range !== want.out_of_range ||
              got.bin !== want.bin || got.count !== want.count)
            log_mismatch("wrong result", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready)
        outcome_fifo.push_back(bin_outcome(in_mon.func, in_mon.pos_a, in_mon.pos_b,
                                           in_mon.read_bin));
      mismatches_o <= bad;
      pending_o    <= outcome_fifo.size();
    end
  end

endmodule

// ----- tb/tb_banded_pair_midpoint_histogram_core.sv -----
`timescale 1ns / 100ps

module tb_banded_pair_midpoint_histogram_core;
  import bmh_pkg::*;
  import bmh_tb_pkg::*;

  localparam longint POS_MAX = (longint'(1) << POS_W) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmh_cfg_if cfg_ch ();
  bmh_in_if  in_ch ();
  bmh_out_if out_ch ();

  int fail_count;
  int pending;

  // no_idle turns off random gaps on both sides for one whole phase
  bit no_idle = 1'b0;

  // config as last programmed, used to steer pairs into the band
  longint cur_w = longint'(BIN_WIDTH_RST);
  longint cur_s = longint'(SHIFT_RST);
  longint cur_h = longint'(WINDOW_RST);

  always #5 clk_i = ~clk_i;

  banded_pair_midpoint_histogram_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bmh_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches_o (fail_count),
    .pending_o    (pending)
  );

  // ---------------------------------------------------------------------------
  // Input side. valid stays high across back-to-back items; it only drops
  // for a random gap or in drain, so there is one assignment to it per time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic f, input logic [POS_W-1:0] a,
                           input logic [POS_W-1:0] b, input logic [BIN_W-1:0] rb);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 40);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.pos_a    <= a;
    in_ch.pos_b    <= b;
    in_ch.read_bin <= rb;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // the field an operation ignores carries random bits
  task automatic send_record(input longint a, input longint b);
    send_item(FUNC_RECORD, POS_W'(a), POS_W'(b), BIN_W'($urandom));
  endtask

  task automatic send_read(input int rb);
    send_item(FUNC_READ, POS_W'($urandom), POS_W'($urandom), BIN_W'(rb));
  endtask

  // Drop valid and wait for the last result; the block is idle after that
  // since every item yields exactly one result.
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= POS_W'(data);
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Program one band setting; the spare index must leave everything alone.
  task automatic set_band(input longint w, input longint s, input longint h);
    write_reg(CFG_SPARE, longint'($urandom));
    write_reg(CFG_WINDOW, h);
    write_reg(CFG_BIN_WIDTH, w);
    write_reg(CFG_SHIFT, s);
    cfg_ch.valid <= 1'b0;
    cur_w = w;
    cur_s = s;
    cur_h = h;
  endtask

  // Well-formed pair: distance inside the band (edges and just-outside
  // bounds now and then), midpoint aimed at a chosen bin, mostly low bins
  // so that reads see real counts, a few just past the store.
  task automatic pick_pair(output longint a, output longint b);
    longint lo_d;
    longint hi_d;
    longint d;
    longint w;
    longint k;
    longint mid;
    longint base;
    int     sel;
    w    = (cur_w == 0) ? 1 : cur_w;
    lo_d = cur_s - cur_h + 1;
    hi_d = cur_s + cur_h - 1;
    if (lo_d < 0) lo_d = 0;
    if (hi_d > POS_MAX) hi_d = POS_MAX;
    sel = $urandom_range(0, 99);
    if (lo_d > hi_d) d = $urandom_range(0, 3) == 0 ? cur_s : longint'($urandom_range(0, 4095));
    else if (sel < 10) d = lo_d;
    else if (sel < 20) d = hi_d;
    else if (sel < 25) d = cur_s - cur_h;
    else if (sel < 30) d = cur_s + cur_h;
    else d = lo_d + longint'($urandom_range(0, 32'(hi_d - lo_d)));
    if (d < 0) d = 0;
    if (d > POS_MAX) d = POS_MAX;
    sel = $urandom_range(0, 99);
    if (sel < 50) k = $urandom_range(0, 31);
    else if (sel < 95) k = $urandom_range(0, NUM_BINS - 1);
    else k = $urandom_range(NUM_BINS, NUM_BINS + 3);
    mid  = k * w + longint'($urandom_range(0, 32'(w - 1)));
    base = mid - (d >>> 1);
    if (base > POS_MAX - d) base = POS_MAX - d;
    if (base < 0) base = 0;
    if ($urandom_range(0, 1) == 1) begin
      a = base;
      b = base + d;
    end else begin
      a = base + d;
      b = base;
    end
  endtask

  // Mostly in-band records, some reads, some raw noise pairs.
  task automatic run_mix(input int n);
    longint a;
    longint b;
    int     sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        if ($urandom_range(0, 1) == 1) send_read($urandom_range(0, 31));
        else send_read($urandom);
      end else if (sel < 35) begin
        a = longint'(POS_W'($urandom));
        if ($urandom_range(0, 1) == 1) b = longint'(POS_W'($urandom));
        else b = longint'(POS_W'(a ^ longint'($urandom_range(0, 65535))));
        send_record(a, b);
      end else begin
        pick_pair(a, b);
        send_record(a, b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off after a few
  // dozen results while the sender keeps offering, so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int seen;
    int hold;
    bit squeezed;
    seen     = 0;
    hold     = 0;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) seen++;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (seen == 60 && !squeezed) begin
        squeezed = 1'b1;
        hold     = 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FUNC_RECORD;
    in_ch.pos_a    <= '0;
    in_ch.pos_b    <= '0;
    in_ch.read_bin <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_BIN_WIDTH;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: shift 0, window 1e6, so the lower bound is negative.
    // The first item waits out the post-reset clear through ready.
    send_read(0);
    send_read(NUM_BINS - 1);
    send_record(0, 0);
    send_record(POS_MAX, POS_MAX);
    send_record(0, 999999);
    send_record(0, 1000000);          // upper bound is exclusive
    send_record(1000000, 0);
    send_record(POS_MAX, 0);
    send_record(0, 0);                // same bin again
    send_read(0);
    send_read(6710);
    run_mix(120);
    drain();

    // Unit bins: midpoints past 8191 fall off the store.
    set_band(1, 0, 4000);
    send_record(8191, 8191);
    send_record(8192, 8192);
    send_record(8191, 8194);
    send_record(8190, 8193);
    send_read(NUM_BINS - 1);
    run_mix(90);
    drain();

    // Zero width acts as one; band (50, 150) with exclusive edges.
    set_band(0, 100, 50);
    send_record(10, 110);
    send_record(0, 50);
    send_record(0, 150);
    send_record(0, 149);
    run_mix(90);
    drain();

    // All registers at their top value, run without any idling.
    set_band(POS_MAX, POS_MAX, POS_MAX);
    send_record(0, POS_MAX);
    send_record(5, 5);                // zero distance sits on the lower bound
    no_idle = 1'b1;
    run_mix(100);
    drain();
    no_idle = 1'b0;

    // Zero window: the band is empty.
    set_band(1000, 5000, 0);
    run_mix(80);
    drain();

    set_band(32768, 2000000, 1500000);
    run_mix(90);
    drain();

    set_band(12345, 0, 0);
    run_mix(60);
    drain();

    // Window one: only a distance equal to the shift gets in.
    set_band(7, 3000, 1);
    run_mix(90);
    drain();

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bmh_pkg.sv
sv/bmh_channels.sv
sv/bmh_ram.sv
sv/bmh_div.sv
sv/bmh_datapath.sv
sv/bmh_ctrl.sv
sv/banded_pair_midpoint_histogram_core.sv
tb/bmh_tb_pkg.sv
tb/bmh_checker.sv
tb/tb_banded_pair_midpoint_histogram_core.sv
